>>> rtl/status_led_mode_flasher_macros.svh
// ----------------------------------------------------------------------------
// Status LED mode flasher: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_MODE_FLASHER_MACROS_SVH
`define STATUS_LED_MODE_FLASHER_MACROS_SVH

// Same-cycle implication.
`define SLED_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SLED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sled_pkg.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher: package
// Types, codes, reset values and the colour table shared by the block.
// ----------------------------------------------------------------------------
package sled_pkg;

	localparam int unsigned TIME_BITS_DEF = 32;
	localparam int unsigned HP_W          = 31;
	localparam int unsigned CFG_W         = 31;

	// request function codes
	typedef logic [1:0] func_t;
	localparam func_t FUNC_LINK  = 2'd0;
	localparam func_t FUNC_DRIVE = 2'd1;
	localparam func_t FUNC_TICK  = 2'd2;

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BRIGHTNESS  = 2'd0;
	localparam reg_idx_t REG_HALF_PERIOD = 2'd1;
	localparam reg_idx_t REG_CENTER      = 2'd2;
	localparam reg_idx_t REG_TOLERANCE   = 2'd3;

	localparam logic [7:0]      BRIGHT_RST = 8'd255;
	localparam logic [HP_W-1:0] HALF_RST   = HP_W'(1);
	localparam logic [7:0]      CENTER_RST = 8'd90;
	localparam logic [7:0]      TOL_RST    = 8'd0;

	typedef enum logic [1:0] {
		MODE_DISCONNECTED = 2'd0,
		MODE_CONNECTED    = 2'd1,
		MODE_DRIVING      = 2'd2,
		MODE_TURNING      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIVIDE,
		ST_MULT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load;
		logic step;
		logic mult;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tick;
		logic flashing;
		logic div_last;
		logic changed;
		logic slot_free;
	} sts_t;

	function automatic rgb_t colour_of(mode_t m);
		rgb_t c;
		case (m)
			MODE_DISCONNECTED: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			MODE_CONNECTED:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
			MODE_DRIVING:      c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
			MODE_TURNING:      c = '{r: 8'd160, g: 8'd0,   b: 8'd255};
			default:           c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
		endcase
		return c;
	endfunction

	function automatic logic is_flashing(mode_t m);
		return (m == MODE_DRIVING) || (m == MODE_TURNING);
	endfunction

	function automatic mode_t wanted_mode(logic link, logic moving, logic off_centre);
		mode_t m;
		if (moving) begin
			m = off_centre ? MODE_TURNING : MODE_DRIVING;
		end else begin
			m = link ? MODE_CONNECTED : MODE_DISCONNECTED;
		end
		return m;
	endfunction

	// floor(x / 255), exact for x up to 255 * 255
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] sum;
		sum = 17'(x) + 17'd1 + 17'(x[15:8]);
		return sum[15:8];
	endfunction

endpackage

>>> rtl/sled_if.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher: channel interfaces
// Valid/ready request channel and result channel.
// ----------------------------------------------------------------------------
interface sled_in_if;
	logic               valid;
	logic               ready;
	sled_pkg::func_t    func;
	logic               link_up;
	logic signed [15:0] motor_duty;
	logic [7:0]         steer_angle;
	logic [31:0]        now_ms;

	modport source (output valid, func, link_up, motor_duty, steer_angle, now_ms,
		input ready);
	modport sink (input valid, func, link_up, motor_duty, steer_angle, now_ms,
		output ready);
endinterface

interface sled_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> rtl/sled_ctrl.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher: controller
// Sequences one update tick through load, divide (flashing modes only), multiply and emit.
// ----------------------------------------------------------------------------
module sled_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sled_pkg::sts_t sts,
	output sled_pkg::cmd_t cmd
);
	import sled_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.tick) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.flashing ? ST_DIVIDE : ST_MULT;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				// drop an unchanged colour, hold a changed one until the slot frees
				if (!sts.changed) begin
					state_d = ST_IDLE;
				end else if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/sled_dp.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher: datapath
// Configuration, flags, mode, serial phase divider, colour scaling, output.
// ----------------------------------------------------------------------------
module sled_dp #(
	parameter int unsigned TIME_BITS = sled_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  sled_pkg::reg_idx_t         cfg_index,
	input  logic [sled_pkg::CFG_W-1:0] cfg_data,
	input  sled_pkg::func_t            func,
	input  logic                       link_up,
	input  logic signed [15:0]         motor_duty,
	input  logic [7:0]                 steer_angle,
	input  logic [31:0]                now_ms,
	input  sled_pkg::cmd_t             cmd,
	output sled_pkg::sts_t             sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue
);
	import sled_pkg::*;

	localparam int unsigned CNT_W = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;

	logic [7:0]      bright_q;
	logic [HP_W-1:0] half_q;
	logic [7:0]      center_q;
	logic [7:0]      tol_q;

	logic            link_q;
	logic            moving_q;
	logic            offc_q;
	mode_t           mode_q;
	logic [TIME_BITS-1:0] phase_q;
	logic [TIME_BITS-1:0] now_q;

	logic [TIME_BITS-1:0] div_q;
	logic [HP_W-1:0]      rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 qbit_q;

	logic [15:0] prod_r_q;
	logic [15:0] prod_g_q;
	logic [15:0] prod_b_q;

	logic        out_valid_q;
	logic        written_q;
	rgb_t        out_q;

	logic [TIME_BITS-1:0] now_tb;
	logic [7:0]           offset;
	mode_t                want;
	logic [HP_W:0]        shifted;
	logic [HP_W:0]        diff;
	logic                 ge;
	rgb_t                 colour;
	rgb_t                 cand;

	assign now_tb = TIME_BITS'(now_ms);
	assign offset = (steer_angle >= center_q) ? (steer_angle - center_q)
	                                          : (center_q - steer_angle);
	assign want   = wanted_mode(link_q, moving_q, offc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_RST;
			half_q   <= HALF_RST;
			center_q <= CENTER_RST;
			tol_q    <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS:  bright_q <= cfg_data[7:0];
				REG_HALF_PERIOD: half_q   <= (cfg_data[HP_W-1:0] == '0) ? HALF_RST
				                                                      : cfg_data[HP_W-1:0];
				REG_CENTER:      center_q <= cfg_data[7:0];
				REG_TOLERANCE:   tol_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// flags, mode and phase origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q   <= 1'b0;
			moving_q <= 1'b0;
			offc_q   <= 1'b0;
			mode_q   <= MODE_DISCONNECTED;
			phase_q  <= '0;
		end else if (cmd.take) begin
			case (func)
				FUNC_LINK: begin
					link_q <= link_up;
				end
				FUNC_DRIVE: begin
					moving_q <= (motor_duty != 16'sd0);
					offc_q   <= (offset > tol_q);
				end
				FUNC_TICK: begin
					if (want != mode_q) begin
						mode_q <= want;
						if (!is_flashing(mode_q)) begin
							phase_q <= now_tb;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			now_q <= now_tb;
		end
	end

	// restoring divider, one quotient bit per cycle; only the last bit is kept
	assign shifted = {rem_q, div_q[TIME_BITS-1]};
	assign diff    = shifted - {1'b0, half_q};
	assign ge      = (shifted >= {1'b0, half_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q  <= now_q - phase_q;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(TIME_BITS - 1);
			qbit_q <= 1'b0;
		end else if (cmd.step) begin
			div_q  <= div_q << 1;
			rem_q  <= ge ? diff[HP_W-1:0] : shifted[HP_W-1:0];
			cnt_q  <= cnt_q - CNT_W'(1);
			qbit_q <= ge;
		end
	end

	assign colour = colour_of(mode_q);

	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_r_q <= 16'(colour.r) * 16'(bright_q);
			prod_g_q <= 16'(colour.g) * 16'(bright_q);
			prod_b_q <= 16'(colour.b) * 16'(bright_q);
		end
	end

	always_comb begin
		if (qbit_q) begin
			cand = '0;
		end else begin
			cand.r = div255(prod_r_q);
			cand.g = div255(prod_g_q);
			cand.b = div255(prod_b_q);
		end
	end

	// output register doubles as the last colour sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			written_q   <= 1'b0;
			out_q       <= '0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
			written_q   <= 1'b1;
			out_q       <= cand;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.tick      = (func == FUNC_TICK);
	assign sts.flashing  = is_flashing(mode_q);
	assign sts.div_last  = (cnt_q == '0);
	assign sts.changed   = !written_q || (cand != out_q);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign red       = out_q.r;
	assign green     = out_q.g;
	assign blue      = out_q.b;

endmodule

>>> rtl/status_led_mode_flasher.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher
// Keeps the display mode of a status pixel and emits its scaled colour.
// ----------------------------------------------------------------------------
// Link-status and drive requests only update flags;
// an update tick settles the display mode, works out the flash phase and
// emits a colour only when it differs from the last one sent. A tick holds
// the request side until it is done; in a flashing mode the bit-serial
// restoring divider forms (now - phase start) / half period one quotient
// bit per cycle, while a tick in a steady mode skips the divider. A tick
// whose colour changed waits further if the previous result has not yet
// been taken. Requests are taken while a result still sits in the output
// register.
module status_led_mode_flasher #(
	parameter int unsigned TIME_BITS = sled_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  sled_pkg::reg_idx_t         cfg_index,
	input  logic [sled_pkg::CFG_W-1:0] cfg_data,
	sled_in_if.sink                    items,
	sled_out_if.source                 results
);
	import sled_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence each tick: accept, load divider, divide (flashing modes only), scale, emit
	sled_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// state, divider, scaler and the output register that parts the two sides
	sled_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (items.func),
		.link_up     (items.link_up),
		.motor_duty  (items.motor_duty),
		.steer_angle (items.steer_angle),
		.now_ms      (items.now_ms),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.red         (results.red),
		.green       (results.green),
		.blue        (results.blue)
	);

endmodule

>>> rtl/sled_checker.sv
// ----------------------------------------------------------------------------
// Status LED mode flasher: port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "status_led_mode_flasher_macros.svh"

module sled_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input sled_pkg::func_t in_func,
	input logic            out_valid,
	input logic            out_ready,
	input logic [7:0]      red,
	input logic [7:0]      green,
	input logic [7:0]      blue
);
	import sled_pkg::*;

	logic [23:0] prev_q;
	logic        have_q;
	logic [23:0] colour;

	assign colour = {red, green, blue};

	// last colour taken from the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			prev_q <= colour;
			have_q <= 1'b1;
		end
	end

	`SLED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`SLED_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(colour), "stalled result changed")
	`SLED_ASSERT_IMPL(a_no_repeat, out_valid && have_q, colour != prev_q, "colour repeated")
	`SLED_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && (in_func == FUNC_TICK), !in_ready, "tick not held")

endmodule

bind status_led_mode_flasher sled_checker u_sled_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_func   (items.func),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.red       (results.red),
	.green     (results.green),
	.blue      (results.blue)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status LED mode flasher: testbench
// Sends link, drive and tick requests in random bursts, runs a predictor of
// the display mode, flash phase and brightness scaling alongside the block,
// and compares every colour it emits, in order, with the predicted one.
// ----------------------------------------------------------------------------
module testbench;
	import sled_pkg::*;

	// the one function code that the block ignores
	localparam func_t FUNC_UNUSED = 2'd3;
	localparam int    SETTLE_CYCLES = 60;
	localparam int    PHASE_REQS = 115;
	localparam int    PHASES = 10;

	typedef struct {
		func_t              func;
		logic               link_up;
		logic signed [15:0] motor_duty;
		logic [7:0]         steer_angle;
		logic [31:0]        now_ms;
	} led_req_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	reg_idx_t             cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sled_in_if  req_ch ();
	sled_out_if hue_ch ();

	status_led_mode_flasher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (req_ch),
		.results   (hue_ch)
	);

	// ------------------------------------------------------------------
	// Predictor state: a shadow of the registers and of the display state
	// ------------------------------------------------------------------
	logic [7:0]      bright_cfg;
	logic [HP_W-1:0] half_cfg;
	logic [7:0]      center_cfg;
	logic [7:0]      tol_cfg;

	logic        link_seen;
	logic        moving;
	logic        off_centre;
	mode_t       shown_mode;
	logic [31:0] flash_origin;
	rgb_t        last_sent;
	logic        sent_any;

	// colours the block still owes, oldest first
	rgb_t colour_due[$];
	// requests waiting for the driver
	led_req_t req_backlog[$];

	int reqs_queued;
	int reqs_taken;
	int mismatch_count;

	// Stimulus time base: ticks mostly move forward from here.
	logic [31:0] stim_ms;

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: apply one accepted request, queue the colour it sends
	// ------------------------------------------------------------------
	function automatic void advance_display(led_req_t rq);
		mode_t       goal;
		logic        was_flashing;
		logic        lit;
		logic [31:0] elapsed;
		rgb_t        hue;
		rgb_t        shown;
		int          offset;
		case (rq.func)
			FUNC_LINK: begin
				link_seen = rq.link_up;
			end
			FUNC_DRIVE: begin
				moving = (rq.motor_duty != 16'sd0);
				offset = int'(rq.steer_angle) - int'(center_cfg);
				if (offset < 0) begin
					offset = -offset;
				end
				off_centre = (offset > int'(tol_cfg));
			end
			FUNC_TICK: begin
				if (moving) begin
					goal = off_centre ? MODE_TURNING : MODE_DRIVING;
				end else begin
					goal = link_seen ? MODE_CONNECTED : MODE_DISCONNECTED;
				end
				// restart the phase only when leaving a steady mode
				if (goal != shown_mode) begin
					was_flashing = (shown_mode == MODE_DRIVING) || (shown_mode == MODE_TURNING);
					shown_mode = goal;
					if (!was_flashing) begin
						flash_origin = rq.now_ms;
					end
				end
				lit = 1'b1;
				if ((shown_mode == MODE_DRIVING) || (shown_mode == MODE_TURNING)) begin
					elapsed = rq.now_ms - flash_origin;
					lit = ((elapsed / {1'b0, half_cfg}) & 32'd1) == 32'd0;
				end
				case (shown_mode)
					MODE_DISCONNECTED: hue = '{r: 8'd255, g: 8'd0,   b: 8'd0};
					MODE_CONNECTED:    hue = '{r: 8'd0,   g: 8'd255, b: 8'd0};
					MODE_DRIVING:      hue = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
					default:           hue = '{r: 8'd160, g: 8'd0,   b: 8'd255};
				endcase
				shown.r = lit ? 8'((32'(hue.r) * 32'(bright_cfg)) / 32'd255) : 8'd0;
				shown.g = lit ? 8'((32'(hue.g) * 32'(bright_cfg)) / 32'd255) : 8'd0;
				shown.b = lit ? 8'((32'(hue.b) * 32'(bright_cfg)) / 32'd255) : 8'd0;
				// an unchanged colour is not sent again
				if (!sent_any || shown != last_sent) begin
					last_sent = shown;
					sent_any = 1'b1;
					colour_due.push_back(shown);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void note_mismatch(string what, rgb_t want, rgb_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
				$realtime, what, want.r, want.g, want.b, got.r, got.g, got.b);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver: bursts of random length with random gaps between
	// ------------------------------------------------------------------
	led_req_t cur_req;
	int       burst_left;
	int       gap_left;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			// predict at acceptance so the shadow state follows request order
			if (req_ch.valid && req_ch.ready) begin
				advance_display(cur_req);
				reqs_taken++;
			end
			// drive the next request only once the current one has gone
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					cur_req = req_backlog.pop_front();
					req_ch.func        <= cur_req.func;
					req_ch.link_up     <= cur_req.link_up;
					req_ch.motor_duty  <= cur_req.motor_duty;
					req_ch.steer_angle <= cur_req.steer_angle;
					req_ch.now_ms      <= cur_req.now_ms;
					req_ch.valid       <= 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						// a new burst; a quarter of them follow with no gap at all
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: stall on a 16-bit pattern, reloaded each round
	// ------------------------------------------------------------------
	logic [15:0] ready_pat;
	int          ready_pos;

	always @(posedge clk) begin
		if (!arst_n) begin
			hue_ch.ready <= 1'b0;
			ready_pat = 16'hffff;
			ready_pos = 0;
		end else begin
			if (ready_pos == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2: ready_pat = 16'hffff;
					3, 4:    ready_pat = 16'($urandom) & 16'($urandom);
					5:       ready_pat = 16'h0001;
					default: ready_pat = 16'($urandom);
				endcase
			end
			hue_ch.ready <= ready_pat[ready_pos];
			ready_pos = (ready_pos + 1) % 16;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: check every accepted colour against the oldest one due
	// ------------------------------------------------------------------
	rgb_t got_hue;
	rgb_t want_hue;

	always @(posedge clk) begin
		if (arst_n && hue_ch.valid && hue_ch.ready) begin
			got_hue = '{r: hue_ch.red, g: hue_ch.green, b: hue_ch.blue};
			if (colour_due.size() == 0) begin
				note_mismatch("colour with none due", '{r: 8'd0, g: 8'd0, b: 8'd0}, got_hue);
			end else begin
				want_hue = colour_due.pop_front();
				if (got_hue.r != want_hue.r || got_hue.g != want_hue.g
						|| got_hue.b != want_hue.b) begin
					note_mismatch("colour mismatch", want_hue, got_hue);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_req(func_t f, logic lk, logic signed [15:0] duty,
			logic [7:0] steer, logic [31:0] ms);
		led_req_t rq;
		rq.func = f;
		rq.link_up = lk;
		rq.motor_duty = duty;
		rq.steer_angle = steer;
		rq.now_ms = ms;
		req_backlog.push_back(rq);
		reqs_queued++;
	endtask

	// Write one register and mirror it into the predictor; only while idle.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_BRIGHTNESS:  bright_cfg = val[7:0];
			REG_HALF_PERIOD: half_cfg = (val[HP_W-1:0] == '0) ? HP_W'(1) : val[HP_W-1:0];
			REG_CENTER:      center_cfg = val[7:0];
			default:         tol_cfg = val[7:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every request is taken and every colour has come back,
	// then let a flash divide that sends nothing run out.
	task automatic wait_idle();
		while (reqs_taken != reqs_queued || colour_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One random request. Mostly ticks marching forward in time and drive
	// commands steered around the centre; some noise and jumps in time.
	task automatic queue_random_req();
		int          pick;
		int          steer;
		int unsigned step_max;
		logic signed [15:0] duty;
		pick = $urandom_range(0, 99);
		duty = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom);
		if ($urandom_range(0, 1) == 0) begin
			steer = int'(center_cfg) + $urandom_range(0, 2 * int'(tol_cfg) + 4)
				- int'(tol_cfg) - 2;
			if (steer < 0) steer = 0;
			if (steer > 255) steer = 255;
		end else begin
			steer = $urandom_range(0, 255);
		end
		step_max = (half_cfg < 64) ? 2 * int'(half_cfg) + 1 : 200;
		if (pick < 50) begin
			if ($urandom_range(0, 9) == 0) begin
				stim_ms = $urandom;
			end else begin
				stim_ms = stim_ms + $urandom_range(0, step_max);
			end
			queue_req(FUNC_TICK, 1'($urandom), 16'($urandom), 8'($urandom), stim_ms);
		end else if (pick < 78) begin
			queue_req(FUNC_DRIVE, 1'($urandom), duty, 8'(steer), $urandom);
		end else if (pick < 93) begin
			queue_req(FUNC_LINK, 1'($urandom), 16'($urandom), 8'($urandom), $urandom);
		end else begin
			// the ignored code; does not count toward the phase length
			queue_req(FUNC_UNUSED, 1'($urandom), 16'($urandom), 8'($urandom), $urandom);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int                 counted;
		logic [7:0]         pb;
		logic [CFG_W-1:0]   ph;
		logic [7:0]         pc;
		logic [7:0]         pt;

		// Drive every input to a known value from time zero.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BRIGHTNESS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LINK;
		req_ch.link_up = 1'b0;
		req_ch.motor_duty = '0;
		req_ch.steer_angle = '0;
		req_ch.now_ms = '0;
		hue_ch.ready = 1'b0;

		// Shadow of the reset state.
		bright_cfg = BRIGHT_RST;
		half_cfg = HALF_RST;
		center_cfg = CENTER_RST;
		tol_cfg = TOL_RST;
		link_seen = 1'b0;
		moving = 1'b0;
		off_centre = 1'b0;
		shown_mode = MODE_DISCONNECTED;
		flash_origin = '0;
		last_sent = '{r: 8'd0, g: 8'd0, b: 8'd0};
		sent_any = 1'b0;
		reqs_queued = 0;
		reqs_taken = 0;
		mismatch_count = 0;
		stim_ms = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, run at the reset settings (half period 1, centre 90,
		// tolerance 0, full brightness).
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd0);          // first colour always sent
		queue_req(FUNC_TICK, 1'b1, 16'sd5, 8'd9, 32'd5);          // unchanged colour, nothing
		queue_req(FUNC_LINK, 1'b1, 16'sd0, 8'd0, 32'd0);
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd6);          // connected, steady green
		queue_req(FUNC_DRIVE, 1'b0, 16'sd1, 8'd90, 32'd0);        // straight ahead
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd100);        // phase restarts, lit blue
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd101);        // dark half
		queue_req(FUNC_DRIVE, 1'b0, 16'sd1, 8'd91, 32'd0);        // one degree off centre
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd102);        // phase kept, lit violet
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd103);
		queue_req(FUNC_DRIVE, 1'b1, -16'sd32768, 8'd0, 32'hffff_ffff);
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd104);
		queue_req(FUNC_UNUSED, 1'b1, -16'sd1, 8'd255, 32'hffff_ffff);
		queue_req(FUNC_DRIVE, 1'b0, 16'sd0, 8'd200, 32'd0);       // stopped, back to steady
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd105);
		queue_req(FUNC_LINK, 1'b0, 16'sd0, 8'd0, 32'd0);          // link lost
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd106);
		queue_req(FUNC_DRIVE, 1'b0, 16'sd32767, 8'd255, 32'd0);
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'hffff_ffff);  // phase starts at the top
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd0);          // elapsed wraps to one
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd1);
		queue_req(FUNC_DRIVE, 1'b1, 16'sd1, 8'd90, 32'd0);
		queue_req(FUNC_TICK, 1'b0, 16'sd0, 8'd0, 32'd2);          // turning to driving, phase kept
		wait_idle();

		// Random phases, the first few at the extremes of the registers.
		for (int ph_i = 0; ph_i < PHASES; ph_i++) begin
			case (ph_i)
				0: begin pb = 8'd0;   ph = 31'd3;          pc = 8'd90;  pt = 8'd5;   end
				1: begin pb = 8'd1;   ph = 31'd0;          pc = 8'd0;   pt = 8'd0;   end
				2: begin pb = 8'd255; ph = 31'h7fff_ffff; pc = 8'd255; pt = 8'd255; end
				3: begin pb = 8'd128; ph = 31'd2;          pc = 8'd128; pt = 8'd10;  end
				default: begin
					pb = 8'($urandom);
					ph = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
					pc = 8'($urandom);
					pt = 8'($urandom_range(0, 40));
				end
			endcase
			write_reg(REG_BRIGHTNESS, CFG_W'(pb));
			write_reg(REG_HALF_PERIOD, ph);
			write_reg(REG_CENTER, CFG_W'(pc));
			write_reg(REG_TOLERANCE, CFG_W'(pt));
			counted = 0;
			while (counted < PHASE_REQS) begin
				queue_random_req();
				if (req_backlog[$].func != FUNC_UNUSED) begin
					counted++;
				end
			end
			wait_idle();
		end

		// Anything still due at this point never arrived.
		while (colour_due.size() != 0) begin
			note_mismatch("colour never sent", colour_due.pop_front(), '{r: 8'd0, g: 8'd0, b: 8'd0});
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
